// ===== design/rgcs_pkg.sv =====
// Shared types and constants for the RSSI gated chunk sender.
// Used by the front, queue, back and top level modules; depends on nothing.
`timescale 1ns / 1ps

package rgcs_pkg;

  // Store and chunk geometry
  localparam int NUM_SAMPLES = 60;
  localparam int CHUNK_LEN   = 20;
  localparam int NUM_CHUNKS  = (NUM_SAMPLES + CHUNK_LEN - 1) / CHUNK_LEN;

  // Store address width, stored count width, chunk offset width
  localparam int ADDR_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam int CNT_W  = $clog2(NUM_SAMPLES + 1);
  localparam int OFF_W  = $clog2(CHUNK_LEN + 1);

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Configuration reset values and good count ceiling
  localparam logic signed [7:0] RSSI_THR_RESET = -8'sd70;
  localparam logic [7:0]        GOOD_MIN_RESET = 8'd3;
  localparam logic [7:0]        GOOD_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_BEACON = 2'd1,
    REQ_ACK    = 2'd2,
    REQ_TICK   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_RSSI_THR = 2'd0,
    CFG_GOOD_MIN = 2'd1
  } cfg_index_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SEND  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] light_sample;
    logic signed [15:0] motion_sample;
    logic [15:0]        src_addr;
    logic signed [7:0]  rssi;
    logic [7:0]         ack_seq;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         chunk_seq;
    logic [7:0]         sample_index;
    logic signed [15:0] light_out;
    logic signed [15:0] motion_out;
    logic               last_in_chunk;
  } out_item_t;

  // Command from front to back: a store write or a chunk send
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  idx;     // write address or chunk base
    logic [7:0]  seq;
    logic [15:0] light;
    logic [15:0] motion;
  } cmd_t;

endpackage

// ===== design/rgcs_front.sv =====
// Front part: accepts items, keeps link and progress state, issues commands.
// Depends on rgcs_pkg.
`timescale 1ns / 1ps

module rgcs_front import rgcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  logic signed [7:0] thr_q;
  logic [7:0]        good_min_q;
  logic [CNT_W-1:0]  stored_count_q, stored_count_d;
  logic              peer_valid_q, peer_valid_d;
  logic [15:0]       peer_addr_q, peer_addr_d;
  logic [7:0]        good_count_q, good_count_d;
  logic [7:0]        next_chunk_q, next_chunk_d;
  logic              accept;
  logic              from_peer;
  logic              store_full;
  logic              chunks_left;

  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !q_full_i;
  assign from_peer   = peer_valid_q && (in_item_i.src_addr == peer_addr_q);
  assign store_full  = (stored_count_q == CNT_W'(NUM_SAMPLES));
  assign chunks_left = (next_chunk_q < 8'(NUM_CHUNKS));

  // Classify the item and update state
  always_comb begin
    stored_count_d = stored_count_q;
    peer_valid_d   = peer_valid_q;
    peer_addr_d    = peer_addr_q;
    good_count_d   = good_count_q;
    next_chunk_d   = next_chunk_q;
    q_push_o       = 1'b0;
    q_cmd_o.kind   = CMD_WRITE;
    q_cmd_o.idx    = 8'(stored_count_q);
    q_cmd_o.seq    = next_chunk_q;
    q_cmd_o.light  = in_item_i.light_sample;
    q_cmd_o.motion = in_item_i.motion_sample;
    if (accept) begin
      case (req_type_e'(in_item_i.req_type))
        REQ_SAMPLE: begin
          if (!store_full) begin
            q_push_o       = 1'b1;
            stored_count_d = stored_count_q + CNT_W'(1);
          end
        end
        REQ_BEACON: begin
          if (in_item_i.rssi >= thr_q) begin
            if (!peer_valid_q) begin
              peer_valid_d = 1'b1;
              peer_addr_d  = in_item_i.src_addr;
              good_count_d = 8'd1;
            end else if (from_peer && good_count_q != GOOD_MAX) begin
              good_count_d = good_count_q + 8'd1;
            end
          end else if (from_peer) begin
            good_count_d = 8'd0;
          end
        end
        REQ_ACK: begin
          if (in_item_i.ack_seq == next_chunk_q && chunks_left) begin
            next_chunk_d = next_chunk_q + 8'd1;
          end
        end
        REQ_TICK: begin
          if (store_full && peer_valid_q && good_count_q >= good_min_q && chunks_left) begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = CMD_SEND;
            q_cmd_o.idx  = 8'(16'(next_chunk_q) * 16'(CHUNK_LEN));
          end
        end
        default: ;
      endcase
    end
  end

  // Hold state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q          <= RSSI_THR_RESET;
      good_min_q     <= GOOD_MIN_RESET;
      stored_count_q <= '0;
      peer_valid_q   <= 1'b0;
      peer_addr_q    <= '0;
      good_count_q   <= '0;
      next_chunk_q   <= '0;
    end else begin
      stored_count_q <= stored_count_d;
      peer_valid_q   <= peer_valid_d;
      peer_addr_q    <= peer_addr_d;
      good_count_q   <= good_count_d;
      next_chunk_q   <= next_chunk_d;
      if (cfg_valid_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_RSSI_THR: thr_q      <= cfg_data_i;
          CFG_GOOD_MIN: good_min_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/rgcs_queue.sv =====
// Short command queue between the front and back parts.
// Depends on rgcs_pkg.
`timescale 1ns / 1ps

module rgcs_queue import rgcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_cmd_o
);

  cmd_t              entry_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o    = (cnt_q == QCNT_W'(Q_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/rgcs_back.sv =====
// Back part: sample store, chunk read sequencer and output register.
// Depends on rgcs_pkg.
`timescale 1ns / 1ps

module rgcs_back import rgcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef struct packed {
    logic [7:0] seq;
    logic [7:0] idx;
    logic       last;
  } rd_meta_t;

  logic [31:0]       mem [NUM_SAMPLES];
  logic              busy_q;
  logic [7:0]        seq_q;
  logic [ADDR_W-1:0] rd_idx_q;
  logic [OFF_W-1:0]  off_q;
  logic              rd_v_q;
  rd_meta_t          rd_meta_q;
  logic [31:0]       rd_data_q;
  logic              out_v_q;
  out_item_t         out_q;
  logic              out_free;
  logic              adv1;
  logic              issue;
  logic              last;

  assign out_free = !out_v_q || !out_stall_i;
  assign adv1     = !rd_v_q || out_free;
  assign issue    = busy_q && adv1;
  assign last     = (off_q == OFF_W'(CHUNK_LEN - 1)) ||
                    (rd_idx_q == ADDR_W'(NUM_SAMPLES - 1));
  assign q_pop_o  = !busy_q && !q_empty_i;

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // Store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_cmd_i.kind == CMD_WRITE) begin
      mem[q_cmd_i.idx[ADDR_W-1:0]] <= {q_cmd_i.light, q_cmd_i.motion};
    end
    if (issue) begin
      rd_data_q <= mem[rd_idx_q];
    end
    if (adv1) begin
      rd_meta_q.seq  <= seq_q;
      rd_meta_q.idx  <= 8'(rd_idx_q);
      rd_meta_q.last <= last;
    end
    if (out_free) begin
      out_q.chunk_seq     <= rd_meta_q.seq;
      out_q.sample_index  <= rd_meta_q.idx;
      out_q.light_out     <= rd_data_q[31:16];
      out_q.motion_out    <= rd_data_q[15:0];
      out_q.last_in_chunk <= rd_meta_q.last;
    end
  end

  // Step through the chunk and move valid flags down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      seq_q    <= '0;
      rd_idx_q <= '0;
      off_q    <= '0;
      rd_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (q_pop_o && q_cmd_i.kind == CMD_SEND) begin
        busy_q   <= 1'b1;
        seq_q    <= q_cmd_i.seq;
        rd_idx_q <= q_cmd_i.idx[ADDR_W-1:0];
        off_q    <= '0;
      end else if (issue) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + ADDR_W'(1);
          off_q    <= off_q + OFF_W'(1);
        end
      end
      if (adv1) begin
        rd_v_q <= issue;
      end
      if (out_free) begin
        out_v_q <= rd_v_q;
      end
    end
  end

endmodule

// ===== design/rssi_gated_chunk_sender_unit.sv =====
// Top level of the RSSI gated chunk sender: front, command queue and back.
// Depends on rgcs_pkg, rgcs_front, rgcs_queue and rgcs_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// The front handles sample, beacon and ack items on acceptance. A send tick
// that qualifies yields min(CHUNK_LEN, pairs left) items, one a cycle while
// out_stall_i is low, passing the queue, chunk sequencer, registered store
// read port and output register; the single store read port sets that pace.
// Input stalls only while the two-entry command queue is full.
// Reset clears all control state; the store needs no clearing.
`timescale 1ns / 1ps

module rssi_gated_chunk_sender_unit import rgcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_empty;
  cmd_t q_pop_cmd;

  // Accept configuration at any time
  assign cfg_ready_o = 1'b1;

  rgcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_push_cmd)
  );

  rgcs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (q_pop_cmd)
  );

  rgcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
